FILE: sv/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int unsigned BLOCK_SIZE_W = 17;
  localparam int unsigned BLOCK_COUNT_W = 11;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 17'd64;
  localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;
  localparam logic [FIELD_W-1:0] BASE_ADDRESS_RESET = 32'd0;

  localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
  localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ALLOC_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_FREE_OUTSIDE = 2'd2;
  localparam logic [1:0] STATUS_FREE_NONE_USED = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] block_address;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_ALLOC_MUL,
    ST_ALLOC_ADD,
    ST_FREE_CHECK,
    ST_DIV,
    ST_PUSH,
    ST_RESULT
  } fsm_state_t;

endpackage

FILE: sv/fixed_block_pool_allocator_top.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator: hands out equal-size blocks of a pool that
// starts at base_address and takes them back on free, keeping free block
// indices on a stack in an internal memory. Items are handled one at a time.
// An allocate steps through EVAL, ALLOC_MUL, ALLOC_ADD and RESULT, a refused
// allocate through EVAL and RESULT, and a rejected free through EVAL,
// FREE_CHECK and RESULT. A successful free converts the address to a block
// index with a restoring divider that produces one quotient bit per cycle.
// After reset the block writes the initial index of every stack entry and
// accepts no transaction until then; configuration writes are taken at any
// time. Results sit in an output register, so a new transaction can be
// accepted while a result waits.

module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned PW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned BW = (CW > BLOCK_COUNT_W) ? CW : BLOCK_COUNT_W;
  localparam int unsigned MW = BW + BLOCK_SIZE_W;
  localparam int unsigned DW = PW + BLOCK_SIZE_W;
  localparam int unsigned AW = ADDRESS_WIDTH;
  localparam int unsigned CMPW = (AW > MW) ? AW : MW;
  localparam int unsigned SW = $clog2(PW) + 1;

  logic [BLOCK_SIZE_W-1:0]  bs_r;
  logic [BLOCK_COUNT_W-1:0] bc_r;
  logic [FIELD_W-1:0]       base_r;

  fsm_state_t state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  in_item_t             item_r, item_nxt;
  logic [MW-1:0]        mul_r;
  logic [AW-1:0]        off_r, off_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic [DW-1:0]        dv_r, dv_nxt;
  logic [PW-1:0]        q_r, q_nxt;
  logic [FIELD_W-1:0]   res_addr_r, res_addr_nxt;
  logic [1:0]           res_status_r, res_status_nxt;

  logic [PW-1:0] stack_mem [MAX_BLOCKS];
  logic [PW-1:0] rd_data_r;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [PW-1:0] mem_wdata;
  logic [PW-1:0] mem_raddr;

  logic [BW-1:0] blocks;
  logic [BW-1:0] mul_b;
  logic [MW-1:0] mul_full;
  logic          cfg_wr;
  logic          q_bit;

  assign blocks = (BW'(bc_r) > BW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(bc_r);
  assign mul_b = (state_r == ST_ALLOC_MUL) ? BW'(rd_data_r) : blocks;
  assign mul_full = MW'(bs_r) * MW'(mul_b);
  assign q_bit = (rem_r >= dv_r);

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_BLOCK_SIZE:   prdata = 32'(bs_r);
      REG_BLOCK_COUNT:  prdata = 32'(bc_r);
      REG_BASE_ADDRESS: prdata = base_r;
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= BLOCK_SIZE_RESET;
      bc_r <= BLOCK_COUNT_RESET;
      base_r <= BASE_ADDRESS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BLOCK_SIZE:   bs_r <= pwdata[BLOCK_SIZE_W-1:0];
        REG_BLOCK_COUNT:  bc_r <= pwdata[BLOCK_COUNT_W-1:0];
        REG_BASE_ADDRESS: base_r <= pwdata;
        default:          ;
      endcase
    end
  end

  assign mem_raddr = used_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= stack_mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt = out_data_r;
    item_nxt = item_r;
    off_nxt = off_r;
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    q_nxt = q_r;
    res_addr_nxt = res_addr_r;
    res_status_nxt = res_status_r;
    mem_we = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = clr_r;
    in_stall = (state_r != ST_IDLE);

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(MAX_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_addr_nxt = '0;
        off_nxt = AW'(item_r.release_address) - AW'(base_r);
        if (item_r.cmd == CMD_ALLOC) begin
          if ((item_r.request_size > FIELD_W'(bs_r)) || (BW'(used_r) >= blocks)) begin
            res_status_nxt = STATUS_ALLOC_REFUSED;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_ALLOC_MUL;
          end
        end else begin
          state_nxt = ST_FREE_CHECK;
        end
      end
      ST_ALLOC_MUL: begin
        state_nxt = ST_ALLOC_ADD;
      end
      ST_ALLOC_ADD: begin
        res_addr_nxt = FIELD_W'(AW'(base_r) + AW'(mul_r));
        res_status_nxt = STATUS_OK;
        used_nxt = used_r + CW'(1);
        state_nxt = ST_RESULT;
      end
      ST_FREE_CHECK: begin
        if ((CMPW'(off_r) >= CMPW'(mul_r)) || (bs_r == '0)) begin
          res_status_nxt = STATUS_FREE_OUTSIDE;
          state_nxt = ST_RESULT;
        end else if (used_r == '0) begin
          res_status_nxt = STATUS_FREE_NONE_USED;
          state_nxt = ST_RESULT;
        end else begin
          rem_nxt = DW'(off_r);
          dv_nxt = DW'(bs_r) << (PW - 1);
          q_nxt = '0;
          cnt_nxt = SW'(PW - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (q_bit) begin
          rem_nxt = rem_r - dv_r;
        end
        q_nxt = (q_r << 1) | PW'(q_bit);
        dv_nxt = dv_r >> 1;
        cnt_nxt = cnt_r - SW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        used_nxt = used_r - CW'(1);
        mem_we = 1'b1;
        mem_waddr = used_nxt[PW-1:0];
        mem_wdata = q_r;
        res_status_nxt = STATUS_OK;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.block_address = res_addr_r;
          out_data_nxt.status = res_status_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      used_r <= '0;
      clr_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    off_r <= off_nxt;
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
    q_r <= q_nxt;
    res_addr_r <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_data_r <= out_data_nxt;
    mul_r <= mul_full;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
